[rtl/ssi_rm_pkg.sv]
package ssi_rm_pkg;

  // Widest word the receiver assembles.
  localparam int MAX_BITS = 32;

  // Field widths of the configuration registers.
  localparam int HALF_PERIOD_W = 8;
  localparam int BIT_DELAY_W   = 8;
  localparam int WORD_BITS_W   = 6;
  localparam int POLL_LIMIT_W  = 10;

  // Configuration write port widths.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIT_DELAY   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = CFG_IDX_W'(3);

  // Tick counter covers the longest phase (the poll window).
  localparam int TICK_W = 10;

  // Live configuration handed from the register bank to the sequencer.
  typedef struct packed {
    logic [HALF_PERIOD_W-1:0] half_period;
    logic [BIT_DELAY_W-1:0]   bit_delay;
    logic [WORD_BITS_W-1:0]   word_bits;
    logic [POLL_LIMIT_W-1:0]  poll_limit;
  } cfg_t;

endpackage

[rtl/ssi_rm_sample_if.sv]
interface ssi_rm_sample_if import ssi_rm_pkg::*; ();
  logic valid;
  logic ready;
  logic cmd;
  logic data_level;

  modport source (output valid, output cmd, output data_level, input ready);
  modport sink (input valid, input cmd, input data_level, output ready);
endinterface

[rtl/ssi_rm_result_if.sv]
interface ssi_rm_result_if import ssi_rm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                clock_level;
  logic                busy_res;
  logic                word_valid;
  logic [MAX_BITS-1:0] position_word;

  modport source (output valid, output clock_level, output busy_res, output word_valid,
                  output position_word, input ready);
  modport sink (input valid, input clock_level, input busy_res, input word_valid,
                input position_word, output ready);
endinterface

[rtl/ssi_rm_cfg_if.sv]
interface ssi_rm_cfg_if import ssi_rm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/ssi_rm_cfg_regs.sv]
module ssi_rm_cfg_regs import ssi_rm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ssi_rm_cfg_if.sink   cfg,
  output cfg_t         regs
);

  // Writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  // Register bank with its reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.half_period <= HALF_PERIOD_W'(2);
      regs.bit_delay   <= BIT_DELAY_W'(0);
      regs.word_bits   <= WORD_BITS_W'(19);
      regs.poll_limit  <= POLL_LIMIT_W'(100);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_PERIOD: regs.half_period <= cfg.data[HALF_PERIOD_W-1:0];
        REG_BIT_DELAY:   regs.bit_delay   <= cfg.data[BIT_DELAY_W-1:0];
        REG_WORD_BITS:   regs.word_bits   <= cfg.data[WORD_BITS_W-1:0];
        REG_POLL_LIMIT:  regs.poll_limit  <= cfg.data[POLL_LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ssi_rm_seq.sv]
module ssi_rm_seq import ssi_rm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             regs,
  ssi_rm_sample_if.sink    sample_ch,
  ssi_rm_result_if.source  result_ch
);

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRE_H1 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRE_L1 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PRE_H2 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_POLL   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd5;
  localparam logic [PHASE_W-1:0] PH_BIT_L  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_BIT_H  = 3'd7;

  localparam int CNT_W = TICK_W + 1;

  // Sequencer state.
  logic [PHASE_W-1:0]     phase, phase_next;
  logic [TICK_W-1:0]      tick_count, tick_count_next;
  logic [WORD_BITS_W-1:0] bits_done, bits_done_next;
  logic [MAX_BITS-1:0]    shift_word, shift_word_next;

  // Result register.
  logic                out_valid;
  logic                out_clock, out_busy, out_word_valid;
  logic [MAX_BITS-1:0] out_word;

  // Combinational results for the current word.
  logic                clk_lvl, busy, done;
  logic [MAX_BITS-1:0] word;

  // Effective lengths after clamping.
  logic [HALF_PERIOD_W-1:0] hp;
  logic [POLL_LIMIT_W-1:0]  poll_len;
  logic [BIT_DELAY_W:0]     sample_len;
  logic [BIT_DELAY_W-1:0]   high_len;
  logic [WORD_BITS_W-1:0]   bit_total;

  logic                     accept;
  logic [PHASE_W-1:0]       ph;
  logic [CNT_W-1:0]         tick_inc;
  logic [WORD_BITS_W-1:0]   bits_inc;

  assign accept          = sample_ch.valid && sample_ch.ready;
  assign sample_ch.ready = !out_valid || result_ch.ready;

  // Phase lengths: zero settings mean one tick, word length is clamped to the shifter.
  always_comb begin
    hp         = (regs.half_period == '0) ? HALF_PERIOD_W'(1) : regs.half_period;
    poll_len   = (regs.poll_limit == '0) ? POLL_LIMIT_W'(1) : regs.poll_limit;
    sample_len = {regs.bit_delay, 1'b1};
    high_len   = (regs.bit_delay == '0) ? BIT_DELAY_W'(1) : regs.bit_delay;
    if (regs.word_bits == '0) begin
      bit_total = WORD_BITS_W'(1);
    end else if (regs.word_bits > WORD_BITS_W'(MAX_BITS)) begin
      bit_total = WORD_BITS_W'(MAX_BITS);
    end else begin
      bit_total = regs.word_bits;
    end
  end

  // One tick of the read sequence.
  always_comb begin
    ph              = phase;
    tick_count_next = tick_count;
    bits_done_next  = bits_done;
    shift_word_next = shift_word;
    if (phase == PH_IDLE && sample_ch.cmd) begin
      ph              = PH_PRE_H1;
      tick_count_next = '0;
      bits_done_next  = '0;
      shift_word_next = '0;
    end
    phase_next = ph;
    tick_inc   = {1'b0, tick_count_next} + CNT_W'(1);
    bits_inc   = bits_done_next + WORD_BITS_W'(1);
    clk_lvl    = 1'b1;
    busy       = 1'b1;
    done       = 1'b0;
    word       = '0;

    case (ph)
      PH_PRE_H1, PH_PRE_L1, PH_PRE_H2, PH_SETTLE: begin
        clk_lvl         = (ph != PH_PRE_L1);
        tick_count_next = tick_inc[TICK_W-1:0];
        if (tick_inc >= CNT_W'(hp)) begin
          tick_count_next = '0;
          case (ph)
            PH_PRE_H1: phase_next = PH_PRE_L1;
            PH_PRE_L1: phase_next = PH_PRE_H2;
            PH_PRE_H2: phase_next = PH_POLL;
            default:   phase_next = PH_BIT_L;
          endcase
        end
      end
      PH_POLL: begin
        clk_lvl         = 1'b0;
        tick_count_next = tick_inc[TICK_W-1:0];
        if (!sample_ch.data_level || tick_inc >= CNT_W'(poll_len)) begin
          phase_next      = PH_SETTLE;
          tick_count_next = '0;
        end
      end
      PH_BIT_L: begin
        clk_lvl = 1'b0;
        // Sample on the middle tick of the low phase.
        if (tick_count_next == TICK_W'(regs.bit_delay)) begin
          shift_word_next = {shift_word_next[MAX_BITS-2:0], sample_ch.data_level};
        end
        tick_count_next = tick_inc[TICK_W-1:0];
        if (tick_inc >= CNT_W'(sample_len)) begin
          phase_next      = PH_BIT_H;
          tick_count_next = '0;
        end
      end
      PH_BIT_H: begin
        clk_lvl         = 1'b1;
        tick_count_next = tick_inc[TICK_W-1:0];
        if (tick_inc >= CNT_W'(high_len)) begin
          tick_count_next = '0;
          if (bits_inc >= bit_total) begin
            done           = 1'b1;
            word           = shift_word_next;
            bits_done_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bits_done_next = bits_inc;
            phase_next     = PH_BIT_L;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        clk_lvl         = 1'b1;
        busy            = 1'b0;
      end
    endcase
  end

  // State advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bits_done  <= '0;
      shift_word <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bits_done  <= bits_done_next;
      shift_word <= shift_word_next;
    end
  end

  // Result register: refilled on every accepted word, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_clock      <= clk_lvl;
      out_busy       <= busy;
      out_word_valid <= done;
      out_word       <= word;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.clock_level   = out_clock;
  assign result_ch.busy_res      = out_busy;
  assign result_ch.word_valid    = out_word_valid;
  assign result_ch.position_word = out_word;

  // A completed word is only ever reported as part of a read.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word_valid |-> out_busy)
    else $error("word completed outside a read");

  // The word field is zero on ticks that complete nothing.
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word_valid |-> out_word == '0)
    else $error("position word not cleared");

  // An idle tick without a start leaves the clock high and the block not busy.
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && !sample_ch.cmd |=> out_clock && !out_busy)
    else $error("idle tick driven wrongly");

  // The bit counter never runs past the shifter width.
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    bits_done < WORD_BITS_W'(MAX_BITS))
    else $error("bit counter out of range");

  // A read always opens with the clock high.
  a_start_high: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && sample_ch.cmd |=> out_clock && out_busy)
    else $error("read start not driven high");

endmodule

[rtl/ssi_encoder_read_master_top.sv]
// SSI absolute encoder read master. Each word on sample_ch is one tick of the
// bit-level sequencer and yields exactly one word on result_ch in the cycle after
// it is accepted: clock_level, busy_res, and word_valid with position_word on
// the tick a read completes. One tick is taken every clock cycle; the only
// limit is the single result register, so sample_ch.ready drops only while a
// result is held and result_ch.ready is low. A read lasts 3*half_period ticks
// of preamble, from one up to poll_limit ticks of polling, half_period ticks of
// settle and then, for each of word_bits bits (0 taken as 1, above 32 as 32),
// 2*bit_delay+1 low ticks and bit_delay high ticks; a zero half_period,
// poll_limit or high-phase bit_delay counts as one tick. Configuration writes
// on cfg are always accepted and must only be issued while no read is in
// progress.
module ssi_encoder_read_master_top import ssi_rm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ssi_rm_sample_if.sink   sample_ch,
  ssi_rm_result_if.source result_ch,
  ssi_rm_cfg_if.sink      cfg
);

  cfg_t regs;

  // Configuration register bank.
  ssi_rm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Read sequencer with its result register.
  ssi_rm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

endmodule
